/* src/bda_pkg.sv */
package bda_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_DATA_W-1:0] ms_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE,
		REG_FIRST_REPEAT,
		REG_REPEAT_INTERVAL,
		REG_REPEAT_MASK
	} cfg_reg_t;

	localparam ms_t DEBOUNCE_RST        = 16'd30;
	localparam ms_t FIRST_REPEAT_RST    = 16'd500;
	localparam ms_t REPEAT_INTERVAL_RST = 16'd150;

endpackage

/* src/bda_sample_if.sv */
interface bda_sample_if #(
	parameter int NUM_BUTTONS = 5,
	parameter int TIME_BITS   = 48
);
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] pin_levels;
	logic [TIME_BITS-1:0]   now_ms;

	modport source (output valid, output pin_levels, output now_ms, input ready);
	modport sink   (input valid, input pin_levels, input now_ms, output ready);
endinterface

/* src/bda_result_if.sv */
interface bda_result_if #(
	parameter int NUM_BUTTONS = 5
);
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] press_events;
	logic [NUM_BUTTONS-1:0] repeat_events;
	logic [NUM_BUTTONS-1:0] stable_state;

	modport source (output valid, output press_events, output repeat_events,
		output stable_state, input ready);
	modport sink   (input valid, input press_events, input repeat_events,
		input stable_state, output ready);
endinterface

/* src/button_debounce_autorepeat.sv */
// A sample word is registered on input, then its result in the result register.
// Throughput: one sample word per cycle while results are taken; all buttons
// are updated in parallel by one pass of compare and add logic between these.
// Reset (arst_n low, asynchronous): buttons read released, timers clear to zero,
// registers return to debounce 30, first repeat 500, interval 150, mask 0.
module button_debounce_autorepeat
	import bda_pkg::*;
#(
	parameter int NUM_BUTTONS = 5,
	parameter int TIME_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bda_sample_if.sink            samples,
	bda_result_if.source          results
);

	ms_t                    debounce_q;
	ms_t                    first_repeat_q;
	ms_t                    interval_q;
	logic [NUM_BUTTONS-1:0] mask_q;

	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] levels_s1;
	logic [TIME_BITS-1:0]   now_s1;
	logic                   adv;

	logic [NUM_BUTTONS-1:0]                raw_q;
	logic [NUM_BUTTONS-1:0]                deb_q;
	logic [NUM_BUTTONS-1:0][TIME_BITS-1:0] chg_q;
	logic [NUM_BUTTONS-1:0][TIME_BITS-1:0] due_q;

	logic [NUM_BUTTONS-1:0]                raw_n;
	logic [NUM_BUTTONS-1:0]                deb_n;
	logic [NUM_BUTTONS-1:0][TIME_BITS-1:0] chg_n;
	logic [NUM_BUTTONS-1:0][TIME_BITS-1:0] due_n;
	logic [NUM_BUTTONS-1:0]                press_n;
	logic [NUM_BUTTONS-1:0]                rep_n;

	logic                   res_valid_q;
	logic [NUM_BUTTONS-1:0] press_q;
	logic [NUM_BUTTONS-1:0] rep_q;
	logic [NUM_BUTTONS-1:0] stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DEBOUNCE_RST;
			first_repeat_q <= FIRST_REPEAT_RST;
			interval_q     <= REPEAT_INTERVAL_RST;
			mask_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE:        debounce_q     <= cfg_wdata;
				REG_FIRST_REPEAT:    first_repeat_q <= cfg_wdata;
				REG_REPEAT_INTERVAL: interval_q     <= cfg_wdata;
				REG_REPEAT_MASK:     mask_q         <= cfg_wdata[NUM_BUTTONS-1:0];
				default:             mask_q         <= mask_q;
			endcase
		end
	end

	assign adv           = valid_s1 && (!res_valid_q || results.ready);
	assign samples.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.valid && samples.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			levels_s1 <= samples.pin_levels;
			now_s1    <= samples.now_ms;
		end
	end

	always_comb begin
		logic [TIME_BITS-1:0] held;
		logic [TIME_BITS-1:0] since_due;
		raw_n   = ~levels_s1;
		deb_n   = deb_q;
		chg_n   = chg_q;
		due_n   = due_q;
		press_n = '0;
		rep_n   = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (raw_n[i] != raw_q[i]) begin
				chg_n[i] = now_s1;
			end
			held = now_s1 - chg_n[i];
			if (raw_n[i] != deb_q[i] && held >= TIME_BITS'(debounce_q)) begin
				deb_n[i] = raw_n[i];
				if (raw_n[i]) begin
					press_n[i] = 1'b1;
					due_n[i]   = now_s1 + TIME_BITS'(first_repeat_q);
				end
			end
			since_due = now_s1 - due_n[i];
			if (deb_n[i] && mask_q[i] && !since_due[TIME_BITS-1]) begin
				rep_n[i] = 1'b1;
				due_n[i] = now_s1 + TIME_BITS'(interval_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0;
			deb_q <= '0;
			chg_q <= '0;
			due_q <= '0;
		end else if (adv) begin
			raw_q <= raw_n;
			deb_q <= deb_n;
			chg_q <= chg_n;
			due_q <= due_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			press_q  <= press_n;
			rep_q    <= rep_n;
			stable_q <= deb_n;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.press_events  = press_q;
	assign results.repeat_events = rep_q;
	assign results.stable_state  = stable_q;

endmodule

/* src/bda_checker.sv */
module bda_checker #(
	parameter int NUM_BUTTONS = 5
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [NUM_BUTTONS-1:0] press_events,
	input logic [NUM_BUTTONS-1:0] repeat_events,
	input logic [NUM_BUTTONS-1:0] stable_state
);

	// A press is only reported for a button that is now stably pressed.
	a_press_is_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((press_events & ~stable_state) == '0))
		else $error("press event on a button that is not stably pressed");

	// A repeat is only reported while the button is held.
	a_repeat_is_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((repeat_events & ~stable_state) == '0))
		else $error("repeat event on a button that is not stably pressed");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word withdrawn before it was taken");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(press_events) && $stable(repeat_events) && $stable(stable_state))
		else $error("stalled result word changed");

endmodule

bind button_debounce_autorepeat bda_checker #(
	.NUM_BUTTONS(NUM_BUTTONS)
) u_bda_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.press_events  (results.press_events),
	.repeat_events (results.repeat_events),
	.stable_state  (results.stable_state)
);

/* dv/button_debounce_autorepeat_tb.sv */
module button_debounce_autorepeat_tb
	import bda_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = 5;
	localparam int TB = 48;
	localparam logic [TB-1:0] T_MAX = {TB{1'b1}};
	localparam int PHASES = 10;
	localparam int WORDS_PER_PHASE = 103;
	localparam int STEADY_PHASE = 3;
	localparam int PRESSURE_PHASE = 6;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int IDLE_PAD = 4;
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		logic [NB-1:0] press;
		logic [NB-1:0] rpt;
		logic [NB-1:0] stable;
	} result_t;

	typedef enum bit {ROW_SETTINGS, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [15:0]   deb;
		logic [15:0]   first;
		logic [15:0]   intv;
		logic [NB-1:0] mask;
		logic [NB-1:0] lv;
		logic [TB-1:0] t;
		bit            typed;
		logic [NB-1:0] want_press;
		logic [NB-1:0] want_rpt;
		logic [NB-1:0] want_stable;
	} plan_row_t;

	plan_row_t directed_plan [0:28] = '{
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd31, 48'd0, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd10, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd40, 1'b1, 5'd31, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd31, 48'd45, 1'b1, 5'd0, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd31, 48'd75, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SETTINGS, 16'd0, 16'd0, 16'd150, 5'd31, 5'd0, 48'd0, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd100, 1'b1, 5'd31, 5'd31, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd249, 1'b1, 5'd0, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd250, 1'b1, 5'd0, 5'd31, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd100, 1'b1, 5'd0, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd31, 48'd500, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SETTINGS, 16'd0, 16'd65535, 16'd150, 5'd31, 5'd0, 48'd0, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b11110, T_MAX - 48'd10, 1'b1,
			5'd1, 5'd0, 5'd1},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b11110, 48'd65523, 1'b1, 5'd0, 5'd0, 5'd1},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b11110, 48'd65524, 1'b1, 5'd0, 5'd1, 5'd1},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd31, T_MAX, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SETTINGS, 16'd65535, 16'd65535, 16'd150, 5'd31, 5'd0, 48'd0, 1'b0,
			5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd0, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd65534, 1'b1, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd65535, 1'b1, 5'd31, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd31, 48'd65536, 1'b1, 5'd0, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd65537, 1'b1, 5'd0, 5'd0, 5'd31},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'd0, 48'd131070, 1'b1, 5'd0, 5'd31, 5'd31},
		'{ROW_SETTINGS, 16'd5, 16'd20, 16'd0, 5'b01010, 5'd0, 48'd0, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b10101, 48'd200000, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b10101, 48'd200005, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b10101, 48'd200025, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b10101, 48'd200025, 1'b0, 5'd0, 5'd0, 5'd0},
		'{ROW_SAMPLE,   16'd0, 16'd0, 16'd0, 5'd0, 5'b01010, 48'd200030, 1'b0, 5'd0, 5'd0, 5'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bda_sample_if #(.NUM_BUTTONS(NB), .TIME_BITS(TB)) sample_bus();
	bda_result_if #(.NUM_BUTTONS(NB)) result_bus();

	button_debounce_autorepeat #(.NUM_BUTTONS(NB), .TIME_BITS(TB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples(sample_bus),
		.results(result_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the block's settings and per-button records.
	logic [15:0] debounce_cfg = DEBOUNCE_RST;
	logic [15:0] first_cfg = FIRST_REPEAT_RST;
	logic [15:0] interval_cfg = REPEAT_INTERVAL_RST;
	logic [NB-1:0] mask_cfg = '0;
	logic [NB-1:0] raw_pressed = '0;
	logic [NB-1:0] stable_pressed = '0;
	logic [TB-1:0] change_at [NB] = '{default: '0};
	logic [TB-1:0] due_at [NB] = '{default: '0};

	result_t awaited_results [$];
	int mismatch_count = 0;
	int words_checked = 0;
	bit no_gaps = 1'b0;
	bit steady = 1'b0;
	bit hold_off_pending = 1'b0;

	function automatic result_t predict_buttons(input logic [NB-1:0] lv, input logic [TB-1:0] t);
		result_t r;
		logic [TB-1:0] held;
		logic [TB-1:0] late;
		int b;
		r = '0;
		for (b = 0; b < NB; b++) begin
			if (!lv[b] != raw_pressed[b]) begin
				raw_pressed[b] = !lv[b];
				change_at[b] = t;
			end
			held = t - change_at[b];
			if (raw_pressed[b] != stable_pressed[b] && held >= {32'd0, debounce_cfg}) begin
				stable_pressed[b] = raw_pressed[b];
				if (stable_pressed[b]) begin
					r.press[b] = 1'b1;
					due_at[b] = t + {32'd0, first_cfg};
				end
			end
			// A due time counts as reached when it lies in the half of the clock behind now.
			late = t - due_at[b];
			if (stable_pressed[b] && mask_cfg[b] && !late[TB-1]) begin
				r.rpt[b] = 1'b1;
				due_at[b] = t + {32'd0, interval_cfg};
			end
		end
		r.stable = stable_pressed;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [NB-1:0] got,
		input logic [NB-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: result word %0d, %s: got %b, want %b", $time, words_checked, what,
				got, want);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("word with none awaited", result_bus.stable_state, '0);
			end else begin
				want = awaited_results.pop_front();
				if (result_bus.press_events !== want.press)
					report_mismatch("press_events", result_bus.press_events, want.press);
				if (result_bus.repeat_events !== want.rpt)
					report_mismatch("repeat_events", result_bus.repeat_events, want.rpt);
				if (result_bus.stable_state !== want.stable)
					report_mismatch("stable_state", result_bus.stable_state, want.stable);
			end
			words_checked++;
		end
	end

	always begin : result_sink
		int n;
		@(posedge clk);
		if (hold_off_pending) begin
			result_bus.ready <= 1'b0;
			for (n = 0; n < HOLD_OFF_CYCLES; n++)
				@(posedge clk);
			hold_off_pending = 1'b0;
		end else if (steady || $urandom_range(0, 3) != 0) begin
			result_bus.ready <= 1'b1;
		end else begin
			result_bus.ready <= 1'b0;
			case ($urandom_range(0, 99)) inside
				[0:84]: n = $urandom_range(0, 2);
				[85:96]: n = $urandom_range(3, 12);
				default: n = $urandom_range(20, 40);
			endcase
			repeat (n) @(posedge clk);
		end
	end

	task automatic send_sample(input logic [NB-1:0] lv, input logic [TB-1:0] t,
		input bit typed, input result_t typed_want);
		result_t predicted;
		int gap;
		sample_bus.valid <= 1'b1;
		sample_bus.pin_levels <= lv;
		sample_bus.now_ms <= t;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		predicted = predict_buttons(lv, t);
		awaited_results.push_back(typed ? typed_want : predicted);
		if (no_gaps) begin
			gap = 0;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:59]: gap = 0;
				[60:89]: gap = $urandom_range(1, 3);
				[90:97]: gap = $urandom_range(4, 10);
				default: gap = $urandom_range(15, 30);
			endcase
		end
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_words();
		sample_bus.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] deb, input logic [15:0] first,
		input logic [15:0] intv, input logic [NB-1:0] mask);
		drain_words();
		cfg_we <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= deb;
		@(posedge clk);
		cfg_index <= REG_FIRST_REPEAT;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= REG_REPEAT_INTERVAL;
		cfg_wdata <= intv;
		@(posedge clk);
		cfg_index <= REG_REPEAT_MASK;
		cfg_wdata <= {{(CFG_DATA_W-NB){1'b0}}, mask};
		@(posedge clk);
		cfg_we <= 1'b0;
		debounce_cfg = deb;
		first_cfg = first;
		interval_cfg = intv;
		mask_cfg = mask;
	endtask

	function automatic logic [15:0] pick_ms();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4, 5, 6: return 16'($urandom_range(1, 40));
			7, 8: return 16'($urandom_range(41, 400));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin : stimulus
		logic [NB-1:0] lv;
		logic [TB-1:0] t;
		logic [63:0] wide;
		int phase;
		int k;
		int b;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_wdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.pin_levels = '1;
		sample_bus.now_ms = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r]) begin
			if (directed_plan[r].kind == ROW_SETTINGS)
				apply_settings(directed_plan[r].deb, directed_plan[r].first,
					directed_plan[r].intv, directed_plan[r].mask);
			else
				send_sample(directed_plan[r].lv, directed_plan[r].t, directed_plan[r].typed,
					'{directed_plan[r].want_press, directed_plan[r].want_rpt,
					directed_plan[r].want_stable});
		end

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				apply_settings(16'd0, 16'd0, 16'd0, 5'd31);
			else if (phase == 1)
				apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31);
			else
				apply_settings(pick_ms(), pick_ms(), pick_ms(), 5'($urandom_range(0, 31)));
			wide = {$urandom, $urandom};
			case (phase % 3)
				0: t = T_MAX - 48'($urandom_range(0, 3000));
				1: t = wide[TB-1:0];
				default: t = 48'($urandom_range(0, 5000));
			endcase
			lv = 5'($urandom_range(0, 31));
			steady = (phase == STEADY_PHASE);
			no_gaps = (phase == STEADY_PHASE) || (phase == PRESSURE_PHASE);
			if (phase == PRESSURE_PHASE)
				hold_off_pending = 1'b1;
			for (k = 0; k < WORDS_PER_PHASE; k++) begin
				// Mostly held or toggled buttons; now and then a burst of noise.
				if ($urandom_range(0, 19) == 0) begin
					lv = 5'($urandom_range(0, 31));
				end else begin
					for (b = 0; b < NB; b++)
						if ($urandom_range(0, 9) == 0)
							lv[b] = !lv[b];
				end
				wide = {$urandom, $urandom};
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: t = t + 48'($urandom_range(0, 8));
					10, 11, 12, 13, 14, 15: t = t + 48'($urandom_range(0, 60));
					16, 17: t = t + 48'($urandom_range(0, 600));
					18: t = t + 48'($urandom_range(0, 70000));
					default: begin
						if (wide[63])
							t = wide[TB-1:0];
						else
							t = t - 48'($urandom_range(1, 5000));
					end
				endcase
				send_sample(lv, t, 1'b0, '0);
			end
			steady = 1'b0;
			no_gaps = 1'b0;
		end

		drain_words();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("button_debounce_autorepeat test passed");
		else
			$display("button_debounce_autorepeat test failed");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("button_debounce_autorepeat test failed");
		$finish;
	end

endmodule
